// File: rtl/mie_pkg.sv
// Shared types, field widths and the microcode program of the modular inverse block.
package mie_pkg;

   localparam int FIELD_BITS = 32;
   localparam int PC_BITS    = 3;
   localparam int UCODE_LEN  = 1 << PC_BITS;

   typedef logic [PC_BITS-1:0] pc_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_UPDATE,
      OP_REDUCE,
      OP_RESULT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_RC_ZERO,
      COND_CNT_NZ,
      COND_OUT_FULL
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ucode_type;

   typedef struct packed {
      logic req_valid;
      logic rc_zero;
      logic cnt_nz;
      logic out_full;
   } status_type;

   localparam pc_type PC_WAIT   = 3'd0;
   localparam pc_type PC_LOOP   = 3'd1;
   localparam pc_type PC_DIV    = 3'd2;
   localparam pc_type PC_UPDATE = 3'd3;
   localparam pc_type PC_REDUCE = 3'd4;
   localparam pc_type PC_RESULT = 3'd5;
   localparam pc_type PC_RETURN = 3'd6;
   localparam pc_type PC_SPARE  = 3'd7;

   // A conditional jump is taken when its condition holds, otherwise the step counter advances.
   localparam ucode_type UCODE [UCODE_LEN] = '{
      '{op: OP_LOAD,     cond: COND_NO_REQ,   target: PC_WAIT},
      '{op: OP_DIV_INIT, cond: COND_RC_ZERO,  target: PC_REDUCE},
      '{op: OP_DIV_STEP, cond: COND_CNT_NZ,   target: PC_DIV},
      '{op: OP_UPDATE,   cond: COND_ALWAYS,   target: PC_LOOP},
      '{op: OP_REDUCE,   cond: COND_NEVER,    target: PC_WAIT},
      '{op: OP_RESULT,   cond: COND_OUT_FULL, target: PC_RESULT},
      '{op: OP_NOP,      cond: COND_ALWAYS,   target: PC_WAIT},
      '{op: OP_NOP,      cond: COND_ALWAYS,   target: PC_WAIT}
   };

endpackage

// File: rtl/mie_if.sv
// Request and response channel interfaces of the modular inverse block.
interface mie_req_if import mie_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] value;
   logic [FIELD_BITS-1:0] modulus;

   modport source (output valid, output value, output modulus, input ready);
   modport sink (input valid, input value, input modulus, output ready);
endinterface

interface mie_rsp_if import mie_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] inverse;
   logic [FIELD_BITS-1:0] common_divisor;
   logic                  has_inverse;

   modport source (output valid, output inverse, output common_divisor, output has_inverse,
                   input ready);
   modport sink (input valid, input inverse, input common_divisor, input has_inverse,
                 output ready);
endinterface

// File: rtl/modular_inverse_ext_gcd.sv
// Top level of the modular inverse block: microcode sequencer and datapath.
// Each request word carries a value and a modulus; the block runs the extended Euclidean
// algorithm and answers with one response word holding the gcd and, when the gcd is 1 and
// the modulus is nonzero, the inverse of the value in 0..modulus-1 (otherwise inverse 0 and
// has_inverse low). Words are taken one at a time. Each Euclid quotient step (up to about 46
// for 32-bit operands) runs a divider set-up, the division and a coefficient update; a
// reduction and the result write follow, and the next request can be taken once the
// sequencer has passed the return step back to the load step. The shared restoring divider
// produces one quotient bit per cycle and forms the coefficient product in the same cycle.
// The response sits in an output register, so the next request is taken while it waits.
module modular_inverse_ext_gcd import mie_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   mie_req_if.sink   req_if,
   mie_rsp_if.source rsp_if
);

   ucode_type  ctrl;
   status_type stat;

   mie_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   mie_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .stat   (stat),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

// File: rtl/mie_seq.sv
// Microcode sequencer: step counter, program table and jump evaluation.
module mie_seq import mie_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type stat,
   output ucode_type  ctrl
);

   pc_type    pc_ff;
   pc_type    pc_in;
   ucode_type word;
   logic      take;

   assign word = UCODE[pc_ff];
   assign ctrl = word;

   always_comb begin
      unique case (word.cond)
         COND_NEVER:    take = 1'b0;
         COND_ALWAYS:   take = 1'b1;
         COND_NO_REQ:   take = !stat.req_valid;
         COND_RC_ZERO:  take = stat.rc_zero;
         COND_CNT_NZ:   take = stat.cnt_nz;
         COND_OUT_FULL: take = stat.out_full;
         default:       take = 1'b1;
      endcase
      pc_in = take ? word.target : pc_ff + pc_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// File: rtl/mie_datapath.sv
// Datapath: remainder and coefficient registers, bit-serial divider with fused multiply, result word.
module mie_datapath import mie_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  ucode_type  ctrl,
   output status_type stat,
   mie_req_if.sink    req_if,
   mie_rsp_if.source  rsp_if
);

   localparam int CNT_BITS = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] mod_ff, mod_in;
   logic [WORD_BITS-1:0] rp_ff, rp_in;
   logic [WORD_BITS-1:0] rc_ff, rc_in;
   logic [WORD_BITS-1:0] tp_ff, tp_in;
   logic [WORD_BITS-1:0] tc_ff, tc_in;
   logic [WORD_BITS-1:0] part_ff, part_in;
   logic [WORD_BITS-1:0] dq_ff, dq_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic                 pneg_ff, pneg_in;
   logic                 cneg_ff, cneg_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 out_valid_ff, out_valid_in;
   logic [WORD_BITS-1:0] inv_ff, inv_in;
   logic [WORD_BITS-1:0] gcd_ff, gcd_in;
   logic                 ok_ff, ok_in;

   logic [WORD_BITS-1:0] in_value;
   logic [WORD_BITS-1:0] in_modulus;
   logic [WORD_BITS:0]   shifted;
   logic [WORD_BITS:0]   diff;
   logic                 qbit;
   logic                 out_full;
   logic                 load_go;
   logic                 result_go;
   logic                 ok_calc;
   logic [WORD_BITS-1:0] inv_calc;

   assign in_value   = WORD_BITS'(req_if.value);
   assign in_modulus = WORD_BITS'(req_if.modulus);

   assign shifted = {part_ff, dq_ff[WORD_BITS-1]};
   assign diff    = shifted - {1'b0, rc_ff};
   assign qbit    = !diff[WORD_BITS];

   assign out_full  = out_valid_ff && !rsp_if.ready;
   assign load_go   = (ctrl.op == OP_LOAD) && req_if.valid;
   assign result_go = (ctrl.op == OP_RESULT) && !out_full;

   assign ok_calc  = (rp_ff == WORD_BITS'(1)) && (mod_ff != '0);
   assign inv_calc = (pneg_ff && (tp_ff != '0)) ? mod_ff - tp_ff : tp_ff;

   assign req_if.ready   = (ctrl.op == OP_LOAD);
   assign stat.req_valid = req_if.valid;
   assign stat.rc_zero   = (rc_ff == '0);
   assign stat.cnt_nz    = (cnt_ff != '0);
   assign stat.out_full  = out_full;

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.inverse        = FIELD_BITS'(inv_ff);
   assign rsp_if.common_divisor = FIELD_BITS'(gcd_ff);
   assign rsp_if.has_inverse    = ok_ff;

   always_comb begin
      mod_in       = mod_ff;
      rp_in        = rp_ff;
      rc_in        = rc_ff;
      tp_in        = tp_ff;
      tc_in        = tc_ff;
      part_in      = part_ff;
      dq_in        = dq_ff;
      acc_in       = acc_ff;
      pneg_in      = pneg_ff;
      cneg_in      = cneg_ff;
      cnt_in       = cnt_ff;
      inv_in       = inv_ff;
      gcd_in       = gcd_ff;
      ok_in        = ok_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      unique case (ctrl.op)
         OP_LOAD: begin
            if (load_go) begin
               // A zero modulus ends the loop at once and reports the value as the divisor.
               mod_in  = in_modulus;
               rp_in   = (in_modulus == '0) ? in_value : in_modulus;
               rc_in   = (in_modulus == '0) ? '0 : in_value;
               tp_in   = '0;
               tc_in   = WORD_BITS'(1);
               pneg_in = 1'b0;
               cneg_in = 1'b0;
            end
         end
         OP_DIV_INIT: begin
            part_in = '0;
            dq_in   = rp_ff;
            acc_in  = '0;
            cnt_in  = CNT_BITS'(WORD_BITS - 1);
         end
         OP_DIV_STEP: begin
            // One quotient bit per cycle; the accumulator builds quotient times coefficient.
            part_in = qbit ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
            dq_in   = {dq_ff[WORD_BITS-2:0], qbit};
            acc_in  = {acc_ff[WORD_BITS-2:0], 1'b0} + (qbit ? tc_ff : '0);
            cnt_in  = cnt_ff - CNT_BITS'(1);
         end
         OP_UPDATE: begin
            rp_in   = rc_ff;
            rc_in   = part_ff;
            tp_in   = tc_ff;
            tc_in   = tp_ff + acc_ff;
            pneg_in = cneg_ff;
            cneg_in = !cneg_ff;
         end
         OP_REDUCE: begin
            if (tp_ff >= mod_ff) begin
               tp_in = tp_ff - mod_ff;
            end
         end
         OP_RESULT: begin
            if (result_go) begin
               inv_in       = ok_calc ? inv_calc : '0;
               gcd_in       = rp_ff;
               ok_in        = ok_calc;
               out_valid_in = 1'b1;
            end
         end
         OP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mod_ff  <= mod_in;
      rp_ff   <= rp_in;
      rc_ff   <= rc_in;
      tp_ff   <= tp_in;
      tc_ff   <= tc_in;
      part_ff <= part_in;
      dq_ff   <= dq_in;
      acc_ff  <= acc_in;
      pneg_ff <= pneg_in;
      cneg_ff <= cneg_in;
      inv_ff  <= inv_in;
      gcd_ff  <= gcd_in;
      ok_ff   <= ok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// File: rtl/mie_checker.sv
// Port-level checker for the modular inverse block and its bind.
module mie_checker import mie_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [FIELD_BITS-1:0] rsp_inverse,
   input logic [FIELD_BITS-1:0] rsp_common_divisor,
   input logic                  rsp_has_inverse
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inverse)
         && $stable(rsp_common_divisor) && $stable(rsp_has_inverse))
      else $error("Response word changed while stalled.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Request taken while another word is in work.");

   a_inverse_gcd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_inverse |-> rsp_common_divisor == FIELD_BITS'(1))
      else $error("Inverse reported with a gcd other than one.");

   a_no_inverse_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_inverse |-> rsp_inverse == '0)
      else $error("Nonzero inverse reported without an inverse.");

endmodule

bind modular_inverse_ext_gcd mie_checker u_mie_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_inverse        (rsp_if.inverse),
   .rsp_common_divisor (rsp_if.common_divisor),
   .rsp_has_inverse    (rsp_if.has_inverse)
);

// File: tb/tb_top.sv
// Self-checking testbench of the modular inverse block: directed table, random words, predictor.
module tb_top import mie_pkg::*; ();

   typedef logic [FIELD_BITS-1:0] field_type;

   typedef struct packed {
      field_type value;
      field_type modulus;
   } inv_request_type;

   typedef struct packed {
      field_type inverse;
      field_type common_divisor;
      logic      has_inverse;
   } inv_result_type;

   typedef struct packed {
      field_type      value;
      field_type      modulus;
      logic           known;
      inv_result_type result;
   } directed_row_type;

   localparam int  RANDOM_WORDS   = 350;
   localparam int  QUIET_WORDS    = 40;
   localparam int  LONG_HOLD      = 5000;
   localparam int  HOLD_AFTER     = 80;
   localparam int  PAUSE_AT       = 200;
   localparam int  DRAIN_CYCLES   = 64;
   localparam int  MAX_REPORTS    = 60;
   localparam real TIMEOUT        = 36_000_000.0;
   localparam int  DIRECTED_ROWS  = 20;

   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{32'd0,          32'd0,          1'b1, '{32'd0, 32'd0,          1'b0}},
      '{32'd5,          32'd0,          1'b1, '{32'd0, 32'd5,          1'b0}},
      '{32'hFFFF_FFFF,  32'd0,          1'b1, '{32'd0, 32'hFFFF_FFFF,  1'b0}},
      '{32'd7,          32'd1,          1'b1, '{32'd0, 32'd1,          1'b1}},
      '{32'd0,          32'd1,          1'b1, '{32'd0, 32'd1,          1'b1}},
      '{32'hFFFF_FFFF,  32'd1,          1'b1, '{32'd0, 32'd1,          1'b1}},
      '{32'd0,          32'd7,          1'b1, '{32'd0, 32'd7,          1'b0}},
      '{32'd1,          32'd7,          1'b1, '{32'd1, 32'd1,          1'b1}},
      '{32'd6,          32'd7,          1'b1, '{32'd6, 32'd1,          1'b1}},
      '{32'd4,          32'd6,          1'b1, '{32'd0, 32'd2,          1'b0}},
      '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, '{32'd0, 32'hFFFF_FFFF,  1'b0}},
      '{32'd3,          32'd7,          1'b0, '{32'd0, 32'd0,          1'b0}},
      '{32'd10,         32'd3,          1'b0, '{32'd0, 32'd0,          1'b0}},
      '{32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b0, '{32'd0, 32'd0,          1'b0}},
      '{32'd1836311903, 32'd2971215073, 1'b0, '{32'd0, 32'd0,          1'b0}},
      '{32'd2971215073, 32'd1836311903, 1'b0, '{32'd0, 32'd0,          1'b0}},
      '{32'd2,          32'hFFFF_FFFF,  1'b0, '{32'd0, 32'd0,          1'b0}},
      '{32'h8000_0000,  32'hFFFF_FFFF,  1'b0, '{32'd0, 32'd0,          1'b0}},
      '{32'hFFFF_FFFE,  32'hFFFF_FFFF,  1'b0, '{32'd0, 32'd0,          1'b0}},
      '{32'h1234_5679,  32'h8000_0000,  1'b0, '{32'd0, 32'd0,          1'b0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   mie_req_if req_ch ();
   mie_rsp_if rsp_ch ();

   inv_result_type pending_results [$];
   inv_result_type oldest_result;
   int             error_count = 0;
   int             words_sent = 0;
   bit             quiet_phase = 1'b0;
   bit             hold_pending = 1'b1;

   modular_inverse_ext_gcd #(
      .WORD_BITS(FIELD_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #6 clock = ~clock;

   function automatic inv_result_type predict_inverse(input field_type value,
                                                      input field_type modulus);
      logic [63:0] rem_old;
      logic [63:0] rem_new;
      logic [63:0] rem_next;
      logic [63:0] quot;
      logic [63:0] coef_old;
      logic [63:0] coef_new;
      logic [63:0] coef_next;
      logic [63:0] reduced;
      logic        neg_old;
      logic        neg_new;
      inv_result_type res;
      res = '0;
      if (modulus == '0) begin
         res.common_divisor = value;
         return res;
      end
      rem_old  = {32'd0, modulus};
      rem_new  = {32'd0, value};
      coef_old = 64'd0;
      coef_new = 64'd1;
      neg_old  = 1'b0;
      neg_new  = 1'b0;
      // Coefficient signs alternate, so only magnitudes are carried and they add.
      while (rem_new != 64'd0) begin
         quot      = rem_old / rem_new;
         rem_next  = rem_old - quot * rem_new;
         coef_next = coef_old + quot * coef_new;
         rem_old   = rem_new;
         rem_new   = rem_next;
         coef_old  = coef_new;
         coef_new  = coef_next;
         neg_old   = neg_new;
         neg_new   = !neg_new;
      end
      res.common_divisor = rem_old[FIELD_BITS-1:0];
      if (rem_old == 64'd1) begin
         reduced = coef_old % {32'd0, modulus};
         res.inverse = (neg_old && reduced != 64'd0) ? modulus - reduced[FIELD_BITS-1:0]
                                                     : reduced[FIELD_BITS-1:0];
         res.has_inverse = 1'b1;
      end
      return res;
   endfunction

   function automatic inv_request_type random_request();
      inv_request_type word;
      field_type       factor;
      word.value   = $urandom;
      word.modulus = $urandom;
      case ($urandom_range(0, 9))
         0: begin
            word.modulus = '0;
            if ($urandom_range(0, 3) == 0) word.value = '0;
         end
         1: word.modulus = 32'd1;
         2, 3, 4: ;
         5, 6: begin
            word.value   = $urandom_range(0, 65535);
            word.modulus = $urandom_range(0, 65535);
         end
         7: word.modulus = $urandom_range(1, 1000);
         8: begin
            factor       = $urandom_range(2, 1000);
            word.value   = factor * field_type'($urandom_range(0, 32'hFFFF_FFFF / factor));
            word.modulus = factor * field_type'($urandom_range(0, 32'hFFFF_FFFF / factor));
         end
         default: begin
            word.value   = field_type'(1) << $urandom_range(0, FIELD_BITS - 1);
            word.modulus = $urandom | 32'd1;
            if ($urandom_range(0, 3) == 0) word.modulus = 32'hFFFF_FFFF;
         end
      endcase
      return word;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic send_request(input inv_request_type word, input logic known,
                               input inv_result_type typed);
      req_ch.valid   <= 1'b1;
      req_ch.value   <= word.value;
      req_ch.modulus <= word.modulus;
      do @(negedge clock); while (!req_ch.ready);
      pending_results.insert(pending_results.size(),
                             known ? typed : predict_inverse(word.value, word.modulus));
      @(posedge clock);
      words_sent++;
   endtask

   task automatic sender_gap();
      if (!quiet_phase && $urandom_range(0, 2) == 0) begin
         req_ch.valid   <= 1'b0;
         req_ch.value   <= $urandom;
         req_ch.modulus <= $urandom;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.value   <= '0;
      req_ch.modulus <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         send_request('{DIRECTED[row].value, DIRECTED[row].modulus},
                      DIRECTED[row].known, DIRECTED[row].result);
         sender_gap();
      end
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS - QUIET_WORDS) quiet_phase = 1'b1;
         if (n == PAUSE_AT) begin
            req_ch.valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         send_request(random_request(), 1'b0, '0);
         sender_gap();
      end
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // The response side stalls in bursts, and once for a long stretch so the input backs up.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_pending && words_sent >= HOLD_AFTER) begin
            hold_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet_phase && $urandom_range(0, 1) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response word with no request outstanding");
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_ch.inverse !== oldest_result.inverse)
               report_mismatch($sformatf("inverse %0d, expected %0d",
                                         rsp_ch.inverse, oldest_result.inverse));
            if (rsp_ch.common_divisor !== oldest_result.common_divisor)
               report_mismatch($sformatf("common_divisor %0d, expected %0d",
                                         rsp_ch.common_divisor, oldest_result.common_divisor));
            if (rsp_ch.has_inverse !== oldest_result.has_inverse)
               report_mismatch($sformatf("has_inverse %b, expected %b",
                                         rsp_ch.has_inverse, oldest_result.has_inverse));
         end
      end
   end

   initial begin
      #(TIMEOUT);
      $display("tb_top failed");
      $finish;
   end

endmodule

// File: files.f
rtl/mie_pkg.sv
rtl/mie_if.sv
rtl/mie_seq.sv
rtl/mie_datapath.sv
rtl/modular_inverse_ext_gcd.sv
rtl/mie_checker.sv
tb/tb_top.sv
